>>> design/pif_pkg.sv
// pif_pkg: register indexes and fixed constants of the plane inlier filter
`timescale 1ns / 1ps

package pif_pkg;

   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_NORMAL_X  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_NORMAL_Y  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_NORMAL_Z  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ANCHOR_X  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ANCHOR_Y  = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ANCHOR_Z  = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TOLERANCE = 3'd6;

   localparam int TOLERANCE_RESET = 655;

endpackage

>>> design/pif_channels.sv
// pif_channels: valid/ready channel interfaces for points in and results out
`timescale 1ns / 1ps

interface pif_req_if #(
   parameter int COORD_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic signed [COORD_WIDTH-1:0] point_z;
   logic                          last_point;

   modport source (output valid, output point_x, output point_y, output point_z,
                   output last_point, input ready);
   modport sink   (input valid, input point_x, input point_y, input point_z,
                   input last_point, output ready);
endinterface

interface pif_rsp_if #(
   parameter int COORD_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] out_x;
   logic signed [COORD_WIDTH-1:0] out_y;
   logic signed [COORD_WIDTH-1:0] out_z;
   logic                          keep;
   logic                          out_last;

   modport source (output valid, output out_x, output out_y, output out_z,
                   output keep, output out_last, input ready);
   modport sink   (input valid, input out_x, input out_y, input out_z,
                   input keep, input out_last, output ready);
endinterface

>>> design/pif_cfg.sv
// pif_cfg: plane registers and the pipelined tolerance^2 * |n|^2 product
`timescale 1ns / 1ps

module pif_cfg #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [pif_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [COORD_WIDTH-1:0]               csr_wdata,
   output logic signed [COORD_WIDTH-1:0]        normal_x,
   output logic signed [COORD_WIDTH-1:0]        normal_y,
   output logic signed [COORD_WIDTH-1:0]        normal_z,
   output logic signed [COORD_WIDTH-1:0]        anchor_x,
   output logic signed [COORD_WIDTH-1:0]        anchor_y,
   output logic signed [COORD_WIDTH-1:0]        anchor_z,
   output logic [4*COORD_WIDTH-3:0]             rhs,
   output logic                                 normal_zero
);
   import pif_pkg::*;

   localparam int W   = COORD_WIDTH;
   localparam int TLW = W - 1;
   localparam int SQW = 2 * W;
   localparam int E2W = 2 * W - 2;
   localparam int PPW = 2 * W - 1;
   localparam int RW  = 4 * W - 2;

   logic signed [W-1:0] normal_x_ff, normal_y_ff, normal_z_ff;
   logic signed [W-1:0] anchor_x_ff, anchor_y_ff, anchor_z_ff;
   logic [TLW-1:0]      tolerance_ff;

   logic [SQW-1:0] sq_x_ff, sq_y_ff, sq_z_ff, sq_x_in, sq_y_in, sq_z_in;
   logic [E2W-1:0] eps2_c1_ff, eps2_c1_in, eps2_c2_ff;
   logic [SQW-1:0] nn_ff, nn_in;
   logic [PPW-1:0] pll_ff, plh_ff, phl_ff, phh_ff;
   logic [PPW-1:0] pll_in, plh_in, phl_in, phh_in;
   logic           nz_c3_ff, nz_c3_in, nz_c4_ff;
   logic [RW-1:0]  rhs_ff, rhs_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_x_ff  <= '0;
         normal_y_ff  <= '0;
         normal_z_ff  <= '0;
         anchor_x_ff  <= '0;
         anchor_y_ff  <= '0;
         anchor_z_ff  <= '0;
         tolerance_ff <= TLW'(TOLERANCE_RESET);
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_NORMAL_X:  normal_x_ff  <= csr_wdata;
            REG_NORMAL_Y:  normal_y_ff  <= csr_wdata;
            REG_NORMAL_Z:  normal_z_ff  <= csr_wdata;
            REG_ANCHOR_X:  anchor_x_ff  <= csr_wdata;
            REG_ANCHOR_Y:  anchor_y_ff  <= csr_wdata;
            REG_ANCHOR_Z:  anchor_z_ff  <= csr_wdata;
            REG_TOLERANCE: tolerance_ff <= csr_wdata[TLW-1:0];
            default: ;
         endcase
      end
   end

   // squares of the normal and of the tolerance
   always_comb begin
      sq_x_in    = $unsigned(SQW'(normal_x_ff) * SQW'(normal_x_ff));
      sq_y_in    = $unsigned(SQW'(normal_y_ff) * SQW'(normal_y_ff));
      sq_z_in    = $unsigned(SQW'(normal_z_ff) * SQW'(normal_z_ff));
      eps2_c1_in = E2W'(tolerance_ff) * E2W'(tolerance_ff);
   end

   // squared length of the normal
   assign nn_in = sq_x_ff + sq_y_ff + sq_z_ff;

   // partial products of eps^2 * |n|^2
   always_comb begin
      pll_in   = PPW'(eps2_c2_ff[W-2:0])     * PPW'(nn_ff[W-1:0]);
      plh_in   = PPW'(eps2_c2_ff[W-2:0])     * PPW'(nn_ff[SQW-1:W]);
      phl_in   = PPW'(eps2_c2_ff[E2W-1:W-1]) * PPW'(nn_ff[W-1:0]);
      phh_in   = PPW'(eps2_c2_ff[E2W-1:W-1]) * PPW'(nn_ff[SQW-1:W]);
      nz_c3_in = (nn_ff == '0);
   end

   assign rhs_in = RW'(pll_ff) + (RW'(plh_ff) << W) + (RW'(phl_ff) << (W - 1))
                 + (RW'(phh_ff) << (2 * W - 1));

   always_ff @(posedge clock) begin
      sq_x_ff    <= sq_x_in;
      sq_y_ff    <= sq_y_in;
      sq_z_ff    <= sq_z_in;
      eps2_c1_ff <= eps2_c1_in;
      nn_ff      <= nn_in;
      eps2_c2_ff <= eps2_c1_ff;
      pll_ff     <= pll_in;
      plh_ff     <= plh_in;
      phl_ff     <= phl_in;
      phh_ff     <= phh_in;
      nz_c3_ff   <= nz_c3_in;
      rhs_ff     <= rhs_in;
      nz_c4_ff   <= nz_c3_ff;
   end

   assign normal_x    = normal_x_ff;
   assign normal_y    = normal_y_ff;
   assign normal_z    = normal_z_ff;
   assign anchor_x    = anchor_x_ff;
   assign anchor_y    = anchor_y_ff;
   assign anchor_z    = anchor_z_ff;
   assign rhs         = rhs_ff;
   assign normal_zero = nz_c4_ff;

endmodule

>>> design/pif_dot.sv
// pif_dot: three-stage pipeline forming n . (p - p0)
`timescale 1ns / 1ps

module pif_dot #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            up_valid,
   output logic                            up_ready,
   input  logic signed [COORD_WIDTH-1:0]   point_x,
   input  logic signed [COORD_WIDTH-1:0]   point_y,
   input  logic signed [COORD_WIDTH-1:0]   point_z,
   input  logic                            last_point,
   input  logic signed [COORD_WIDTH-1:0]   normal_x,
   input  logic signed [COORD_WIDTH-1:0]   normal_y,
   input  logic signed [COORD_WIDTH-1:0]   normal_z,
   input  logic signed [COORD_WIDTH-1:0]   anchor_x,
   input  logic signed [COORD_WIDTH-1:0]   anchor_y,
   input  logic signed [COORD_WIDTH-1:0]   anchor_z,
   output logic                            down_valid,
   input  logic                            down_ready,
   output logic signed [2*COORD_WIDTH+2:0] dot,
   output logic [3*COORD_WIDTH:0]          tag
);
   localparam int W  = COORD_WIDTH;
   localparam int DW = W + 1;
   localparam int PW = 2 * W + 1;
   localparam int SW = 2 * W + 3;
   localparam int TW = 3 * W + 1;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_ready, s2_ready, s3_ready;

   logic signed [DW-1:0] dx_ff, dy_ff, dz_ff, dx_in, dy_in, dz_in;
   logic signed [PW-1:0] px_ff, py_ff, pz_ff, px_in, py_in, pz_in;
   logic signed [SW-1:0] dot_ff, dot_in;
   logic [TW-1:0]        tag1_ff, tag2_ff, tag3_ff;

   assign s3_ready = !s3_valid_ff || down_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign up_ready = s1_ready;

   always_comb begin
      dx_in  = DW'(point_x) - DW'(anchor_x);
      dy_in  = DW'(point_y) - DW'(anchor_y);
      dz_in  = DW'(point_z) - DW'(anchor_z);
      px_in  = PW'(normal_x) * PW'(dx_ff);
      py_in  = PW'(normal_y) * PW'(dy_ff);
      pz_in  = PW'(normal_z) * PW'(dz_ff);
      dot_in = SW'(px_ff) + SW'(py_ff) + SW'(pz_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= up_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         dz_ff   <= dz_in;
         tag1_ff <= {last_point, point_z, point_y, point_x};
      end
      if (s2_ready) begin
         px_ff   <= px_in;
         py_ff   <= py_in;
         pz_ff   <= pz_in;
         tag2_ff <= tag1_ff;
      end
      if (s3_ready) begin
         dot_ff  <= dot_in;
         tag3_ff <= tag2_ff;
      end
   end

   assign down_valid = s3_valid_ff;
   assign dot        = dot_ff;
   assign tag        = tag3_ff;

endmodule

>>> design/pif_test.sv
// pif_test: four-stage pipeline squaring the dot product and comparing
`timescale 1ns / 1ps

module pif_test #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            up_valid,
   output logic                            up_ready,
   input  logic signed [2*COORD_WIDTH+2:0] dot,
   input  logic [3*COORD_WIDTH:0]          tag,
   input  logic [4*COORD_WIDTH-3:0]        rhs,
   input  logic                            normal_zero,
   output logic                            down_valid,
   input  logic                            down_ready,
   output logic                            keep,
   output logic [3*COORD_WIDTH:0]          down_tag
);
   localparam int W  = COORD_WIDTH;
   localparam int SW = 2 * W + 3;
   localparam int MW = 2 * W + 2;
   localparam int HW = W + 1;
   localparam int QW = 2 * HW;
   localparam int LW = 4 * W + 4;
   localparam int TW = 3 * W + 1;

   logic t1_valid_ff, t2_valid_ff, t3_valid_ff, t4_valid_ff;
   logic t1_ready, t2_ready, t3_ready, t4_ready;

   logic signed [SW-1:0] dot_neg;
   logic [MW-1:0]        mag_ff, mag_in;
   logic [QW-1:0]        ll_ff, lh_ff, hh_ff, ll_in, lh_in, hh_in;
   logic [LW-1:0]        lhs_ff, lhs_in;
   logic                 keep_ff, keep_in;
   logic [TW-1:0]        tag1_ff, tag2_ff, tag3_ff, tag4_ff;

   assign t4_ready = !t4_valid_ff || down_ready;
   assign t3_ready = !t3_valid_ff || t4_ready;
   assign t2_ready = !t2_valid_ff || t3_ready;
   assign t1_ready = !t1_valid_ff || t2_ready;
   assign up_ready = t1_ready;

   // magnitude, then its square from three partial products
   always_comb begin
      dot_neg = -dot;
      mag_in  = dot[SW-1] ? MW'(dot_neg) : MW'(dot);
      ll_in   = QW'(mag_ff[HW-1:0])  * QW'(mag_ff[HW-1:0]);
      lh_in   = QW'(mag_ff[HW-1:0])  * QW'(mag_ff[MW-1:HW]);
      hh_in   = QW'(mag_ff[MW-1:HW]) * QW'(mag_ff[MW-1:HW]);
      lhs_in  = LW'(ll_ff) + (LW'(lh_ff) << (HW + 1)) + (LW'(hh_ff) << (2 * HW));
      keep_in = !normal_zero && (lhs_ff < LW'(rhs));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff <= 1'b0;
         t2_valid_ff <= 1'b0;
         t3_valid_ff <= 1'b0;
         t4_valid_ff <= 1'b0;
      end else begin
         if (t1_ready) t1_valid_ff <= up_valid;
         if (t2_ready) t2_valid_ff <= t1_valid_ff;
         if (t3_ready) t3_valid_ff <= t2_valid_ff;
         if (t4_ready) t4_valid_ff <= t3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (t1_ready) begin
         mag_ff  <= mag_in;
         tag1_ff <= tag;
      end
      if (t2_ready) begin
         ll_ff   <= ll_in;
         lh_ff   <= lh_in;
         hh_ff   <= hh_in;
         tag2_ff <= tag1_ff;
      end
      if (t3_ready) begin
         lhs_ff  <= lhs_in;
         tag3_ff <= tag2_ff;
      end
      if (t4_ready) begin
         keep_ff <= keep_in;
         tag4_ff <= tag3_ff;
      end
   end

   assign down_valid = t4_valid_ff;
   assign keep       = keep_ff;
   assign down_tag   = tag4_ff;

endmodule

>>> design/plane_inlier_filter_top.sv
// plane_inlier_filter_top: streaming point-to-plane inlier test
`timescale 1ns / 1ps

// Takes one point per clock while the result output is not stalled and returns one
// result per point, in order; a fully pipelined datapath of seven register stages
// (difference, products, dot sum, magnitude, partial squares, square sum, compare)
// carries each point, and a stalled result output holds the pipeline without loss.
// keep is 1 when (n . (p - p0))^2 < tolerance^2 * |n|^2, computed exactly; a zero
// normal keeps nothing. Register writes take effect for the next accepted point.

module plane_inlier_filter_top #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   pif_req_if.sink                             req_chan,
   pif_rsp_if.source                           rsp_chan,
   input  logic                                csr_write_en,
   input  logic [pif_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COORD_WIDTH-1:0]              csr_wdata
);
   import pif_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int TW = 3 * W + 1;

   logic signed [W-1:0]       normal_x, normal_y, normal_z;
   logic signed [W-1:0]       anchor_x, anchor_y, anchor_z;
   logic [4*W-3:0]            rhs;
   logic                      normal_zero;
   logic                      dot_valid, dot_ready;
   logic signed [2*W+2:0]     dot;
   logic [TW-1:0]             dot_tag, out_tag;

   pif_cfg #(.COORD_WIDTH(COORD_WIDTH)) u_cfg (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .normal_x     (normal_x),
      .normal_y     (normal_y),
      .normal_z     (normal_z),
      .anchor_x     (anchor_x),
      .anchor_y     (anchor_y),
      .anchor_z     (anchor_z),
      .rhs          (rhs),
      .normal_zero  (normal_zero)
   );

   pif_dot #(.COORD_WIDTH(COORD_WIDTH)) u_dot (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req_chan.valid),
      .up_ready   (req_chan.ready),
      .point_x    (req_chan.point_x),
      .point_y    (req_chan.point_y),
      .point_z    (req_chan.point_z),
      .last_point (req_chan.last_point),
      .normal_x   (normal_x),
      .normal_y   (normal_y),
      .normal_z   (normal_z),
      .anchor_x   (anchor_x),
      .anchor_y   (anchor_y),
      .anchor_z   (anchor_z),
      .down_valid (dot_valid),
      .down_ready (dot_ready),
      .dot        (dot),
      .tag        (dot_tag)
   );

   pif_test #(.COORD_WIDTH(COORD_WIDTH)) u_test (
      .clock       (clock),
      .reset       (reset),
      .up_valid    (dot_valid),
      .up_ready    (dot_ready),
      .dot         (dot),
      .tag         (dot_tag),
      .rhs         (rhs),
      .normal_zero (normal_zero),
      .down_valid  (rsp_chan.valid),
      .down_ready  (rsp_chan.ready),
      .keep        (rsp_chan.keep),
      .down_tag    (out_tag)
   );

   assign rsp_chan.out_x    = out_tag[W-1:0];
   assign rsp_chan.out_y    = out_tag[2*W-1:W];
   assign rsp_chan.out_z    = out_tag[3*W-1:2*W];
   assign rsp_chan.out_last = out_tag[3*W];

endmodule
